[rtl/erms_pkg.sv]
`default_nettype none

package erms_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/erms_cell.sv]
`default_nettype none

module erms_cell (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire erms_pkg::t_cell_ctl                    i_ctl,
    input  wire logic                                   i_in_vld,
    input  wire logic signed [erms_pkg::VALUE_W-1:0]    i_in_val,
    input  wire logic                                   i_nb_full,
    input  wire logic signed [erms_pkg::VALUE_W-1:0]    i_nb_val,
    output logic                                        o_out_vld,
    output logic signed [erms_pkg::VALUE_W-1:0]         o_out_val,
    output logic                                        o_full,
    output logic signed [erms_pkg::VALUE_W-1:0]         o_val
);

    logic                                   r_full;
    logic                                   n_full;
    logic signed [erms_pkg::VALUE_W-1:0]    r_val;
    logic signed [erms_pkg::VALUE_W-1:0]    n_val;
    logic                                   r_cv;
    logic                                   n_cv;
    logic signed [erms_pkg::VALUE_W-1:0]    r_cval;
    logic signed [erms_pkg::VALUE_W-1:0]    n_cval;

    // keep the smaller value, hand the larger one to the right
    always_comb begin
        n_val  = r_val;
        n_full = r_full;
        n_cv   = 1'b0;
        n_cval = i_in_val;
        priority if (i_ctl.shift) begin
            n_val  = i_nb_val;
            n_full = i_nb_full;
        end else if (i_in_vld) begin
            priority if (!r_full) begin
                n_val  = i_in_val;
                n_full = 1'b1;
            end else if (i_in_val < r_val) begin
                n_val  = i_in_val;
                n_cv   = 1'b1;
                n_cval = r_val;
            end else begin
                n_cv   = 1'b1;
                n_cval = i_in_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_cv   <= 1'b0;
        end else begin
            r_full <= n_full;
            r_cv   <= n_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_cval <= n_cval;
    end

    assign o_out_vld = r_cv;
    assign o_out_val = r_cval;
    assign o_full    = r_full;
    assign o_val     = r_val;

endmodule

`default_nettype wire

[rtl/extract_runs_merge_sorter.sv]
// order: after the beat marked last, no result is offered until the last insertion
//   has stopped rippling along the cell row
// throughput: one input beat per cycle while loading, one result beat per cycle
//   while draining and i_stall is low; no new set is taken until the last result of
//   the current set has been accepted, and a discarded beat still takes an input beat
// reset: synchronous active low, empties every cell and returns to loading
`default_nettype none

module extract_runs_merge_sorter #(
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic signed [erms_pkg::VALUE_W-1:0]    i_value,
    input  wire logic                                   i_last,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [erms_pkg::VALUE_W-1:0]         o_value_res,
    output logic                                        o_last_res,
    output logic                                        o_dropped
);

    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

    erms_pkg::t_state       r_state;
    erms_pkg::t_state       n_state;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_drop;
    logic                   n_drop;

    erms_pkg::t_cell_ctl    w_ctl;
    logic                   w_in_acc;
    logic                   w_out_acc;
    logic                   w_insert;
    logic                   w_room;

    logic [MAX_ELEMENTS-1:0]                    w_full;
    logic signed [erms_pkg::VALUE_W-1:0]        w_val  [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]                    w_cv;
    logic signed [erms_pkg::VALUE_W-1:0]        w_cval [MAX_ELEMENTS];

    assign o_stall   = (r_state != erms_pkg::ST_LOAD);
    assign w_in_acc  = i_valid && !o_stall;
    assign w_room    = (r_count != CW'(MAX_ELEMENTS));
    assign w_insert  = w_in_acc && w_room;

    assign o_valid     = (r_state == erms_pkg::ST_DRAIN) && w_full[0];
    assign o_value_res = w_val[0];
    assign o_last_res  = !w_full[1];
    assign o_dropped   = o_last_res && r_drop;
    assign w_out_acc   = o_valid && !i_stall;

    assign w_ctl.shift = w_out_acc;

    genvar g;
    generate
        for (g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
            logic                                   w_in_vld;
            logic signed [erms_pkg::VALUE_W-1:0]    w_in_val;
            logic                                   w_nb_full;
            logic signed [erms_pkg::VALUE_W-1:0]    w_nb_val;

            if (g == 0) begin : g_head
                assign w_in_vld = w_insert;
                assign w_in_val = i_value;
            end else begin : g_body
                assign w_in_vld = w_cv[g-1];
                assign w_in_val = w_cval[g-1];
            end

            if (g == MAX_ELEMENTS - 1) begin : g_tail
                assign w_nb_full = 1'b0;
                assign w_nb_val  = '0;
            end else begin : g_mid
                assign w_nb_full = w_full[g+1];
                assign w_nb_val  = w_val[g+1];
            end

            erms_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_in_vld  (w_in_vld),
                .i_in_val  (w_in_val),
                .i_nb_full (w_nb_full),
                .i_nb_val  (w_nb_val),
                .o_out_vld (w_cv[g]),
                .o_out_val (w_cval[g]),
                .o_full    (w_full[g]),
                .o_val     (w_val[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        unique case (r_state)
            erms_pkg::ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_room) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last) begin
                        n_state = erms_pkg::ST_SETTLE;
                    end
                end
            end
            erms_pkg::ST_SETTLE: begin
                // wait until no value is still moving along the row
                if (!(|w_cv)) begin
                    n_state = erms_pkg::ST_DRAIN;
                end
            end
            erms_pkg::ST_DRAIN: begin
                if (w_out_acc && o_last_res) begin
                    n_state = erms_pkg::ST_LOAD;
                    n_count = '0;
                    n_drop  = 1'b0;
                end
            end
            default: begin
                n_state = erms_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= erms_pkg::ST_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

endmodule

`default_nettype wire
